// ----- rtl/outlier_rejecting_average_top_macros.svh -----
// Assertion macros used by the checker of the outlier rejecting average block.
`ifndef OUTLIER_REJECTING_AVERAGE_TOP_MACROS_SVH
`define OUTLIER_REJECTING_AVERAGE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ORAV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orav assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ORAV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orav assertion failed");

`endif

// ----- rtl/orav_pkg.sv -----
// Shared types and constants of the outlier rejecting average block.
package orav_pkg;

	localparam int MAX_SAMPLES_DEF = 8;
	localparam int SAMPLE_W = 16;
	localparam int DROP_W = 6;

	// One input request: a sample and the end-of-set mark.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic last;
	} orav_req_t;

	// One result.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean;
		logic signed [SAMPLE_W-1:0] trimmed_mean;
		logic [DROP_W-1:0] dropped_index;
		logic error;
	} orav_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic scan_init;
		logic rd_scan;
		logic mul;
		logic cmp;
		logic rd_drop;
		logic div_mean;
		logic div_trim;
		logic save_mean;
		logic save_trim;
		logic finish;
	} orav_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic set_err;
		logic scan_last;
		logic div_busy;
		logic out_busy;
	} orav_status_t;

endpackage

// ----- rtl/outlier_rejecting_average_top.sv -----
// Outlier rejecting average: mean and mean without the farthest sample of each set.
// Loading accepts one sample request per cycle; a set closes on the request marked last.
// After the closing request, each sample gets a scan step of read, multiply and compare; then a
// divider with one quotient bit per cycle runs twice over SUM_W = 17 + log2(MAX_SAMPLES) bits.
// A set that is too short or overflows skips the scan and the divisions and gives its error result.
// Reset (arst_n low) clears the count, sum, controller and result valid; the store is not cleared.
module outlier_rejecting_average_top import orav_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  orav_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output orav_rsp_t rsp
);

	orav_cmd_t    cmd;
	orav_status_t st;

	// Controller.
	orav_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_last  (req.last),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath.
	orav_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/orav_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
module orav_div import orav_pkg::*; #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic              ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};

	// Control: step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/orav_ctrl.sv -----
// Controller state machine: loading, deviation scan, two divisions, result hand-off.
module orav_ctrl import orav_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic         req_last,
	output logic         req_ready,
	input  orav_status_t st,
	output orav_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_DRD    = 4'd5;
	localparam logic [3:0] S_DIV1   = 4'd6;
	localparam logic [3:0] S_WAIT1  = 4'd7;
	localparam logic [3:0] S_WAIT2  = 4'd8;
	localparam logic [3:0] S_FINISH = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					if (req_last) begin
						state_nxt = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (st.set_err) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.scan_init = 1'b1;
					state_nxt = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_scan = 1'b1;
				state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_nxt = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_nxt = st.scan_last ? S_DRD : S_RD;
			end
			S_DRD: begin
				cmd.rd_drop = 1'b1;
				state_nxt = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_mean = 1'b1;
				state_nxt = S_WAIT1;
			end
			S_WAIT1: begin
				if (!st.div_busy) begin
					cmd.save_mean = 1'b1;
					cmd.div_trim = 1'b1;
					state_nxt = S_WAIT2;
				end
			end
			S_WAIT2: begin
				if (!st.div_busy) begin
					cmd.save_trim = 1'b1;
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!st.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule

// ----- rtl/orav_dp.sv -----
// Datapath: sample store, count and sum, deviation scan, signed division, result register.
module orav_dp import orav_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  orav_req_t    req,
	input  orav_cmd_t    cmd,
	output orav_status_t st,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output orav_rsp_t    rsp
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 2);
	localparam int SUM_W = SAMPLE_W + 1 + $clog2(MAX_SAMPLES);
	localparam int PROD_W = SAMPLE_W + CNT_W + 1;
	localparam int DEV_W = PROD_W + 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] OVF_CNT = CNT_W'(MAX_SAMPLES + 1);

	logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           scan_q;
	logic [DEV_W-1:0]           best_q;
	logic [IDX_W-1:0]           drop_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SUM_W-1:0]    trim_dvd_q;
	logic                       div_neg_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic signed [SAMPLE_W-1:0] trim_q;
	logic                       rsp_valid_q;
	orav_rsp_t                  rsp_q;
	orav_rsp_t                  rsp_nxt;

	logic signed [PROD_W-1:0]   n_ext;
	logic signed [PROD_W-1:0]   x_ext;
	logic signed [DEV_W-1:0]    diff;
	logic [DEV_W-1:0]           dev;
	logic signed [SUM_W-1:0]    dvd_sel;
	logic [CNT_W-1:0]           dvs_sel;
	logic                       dvd_neg;
	logic [SUM_W-1:0]           dvd_mag;
	logic                       div_start;
	logic                       div_busy;
	logic [SUM_W-1:0]           quo;
	logic [SUM_W-1:0]           quo_fix;

	// Sample store: written while loading, read one entry at a time.
	always_ff @(posedge clk) begin
		if (cmd.take && (cnt_q < MAX_CNT)) begin
			mem[cnt_q[IDX_W-1:0]] <= req.sample;
		end
		if (cmd.rd_scan) begin
			rd_q <= mem[scan_q[IDX_W-1:0]];
		end else if (cmd.rd_drop) begin
			rd_q <= mem[drop_q];
		end
	end

	// Sample count and running sum; the count saturates one past capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.finish) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.take) begin
			if (cnt_q < MAX_CNT) begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(req.sample);
			end else begin
				cnt_q <= OVF_CNT;
			end
		end
	end

	// Deviation |n*x - sum| of the sample just read.
	assign n_ext = signed'(PROD_W'({1'b0, cnt_q}));
	assign x_ext = PROD_W'(rd_q);
	assign diff = DEV_W'(prod_q) - DEV_W'(sum_q);
	assign dev = diff[DEV_W-1] ? unsigned'(-diff) : unsigned'(diff);

	// Scan index, largest deviation so far and its position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_init) begin
			scan_q <= '0;
		end else if (cmd.cmp) begin
			scan_q <= scan_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= n_ext * x_ext;
		end
		if (cmd.scan_init) begin
			best_q <= '0;
			drop_q <= '0;
		end else if (cmd.cmp && (dev > best_q)) begin
			best_q <= dev;
			drop_q <= scan_q[IDX_W-1:0];
		end
	end

	// Divider operands: magnitude in, sign applied to the quotient afterwards.
	assign dvd_sel = cmd.div_trim ? trim_dvd_q : sum_q;
	assign dvs_sel = cmd.div_trim ? CNT_W'(cnt_q - CNT_W'(1)) : cnt_q;
	assign dvd_neg = dvd_sel[SUM_W-1];
	assign dvd_mag = dvd_neg ? unsigned'(-dvd_sel) : unsigned'(dvd_sel);
	assign div_start = cmd.div_mean | cmd.div_trim;
	assign quo_fix = div_neg_q ? -quo : quo;

	orav_div #(
		.DVD_W(SUM_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_mag),
		.divisor  (dvs_sel),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Sign of the running division, the trimmed dividend and the two quotients.
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_neg_q <= dvd_neg;
		end
		if (cmd.div_mean) begin
			trim_dvd_q <= sum_q - SUM_W'(rd_q);
		end
		if (cmd.save_mean) begin
			mean_q <= quo_fix[SAMPLE_W-1:0];
		end
		if (cmd.save_trim) begin
			trim_q <= quo_fix[SAMPLE_W-1:0];
		end
	end

	// Result assembly; an error result carries zeros.
	always_comb begin
		rsp_nxt = '0;
		if (st.set_err) begin
			rsp_nxt.error = 1'b1;
		end else begin
			rsp_nxt.mean = mean_q;
			rsp_nxt.trimmed_mean = trim_q;
			rsp_nxt.dropped_index = DROP_W'(drop_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_nxt;
		end
	end

	// Status to the controller.
	assign st.set_err = (cnt_q < CNT_W'(2)) || (cnt_q > MAX_CNT);
	assign st.scan_last = (CNT_W'(scan_q + CNT_W'(1)) == cnt_q);
	assign st.div_busy = div_busy;
	assign st.out_busy = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ----- rtl/orav_checker.sv -----
// Port-level checker of the outlier rejecting average block and its bind.
`include "outlier_rejecting_average_top_macros.svh"

module orav_checker import orav_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input orav_req_t req,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input orav_rsp_t rsp
);

	// A stalled result holds its value.
	`ORAV_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// An error result carries zeros in every other field.
	`ORAV_ASSERT_IMP(a_err_zero, rsp_valid && rsp.error, (rsp.mean == '0) && (rsp.trimmed_mean == '0) && (rsp.dropped_index == '0))

	// The dropped position lies inside the capacity.
	`ORAV_ASSERT_IMP(a_drop_range, rsp_valid && !rsp.error, int'(rsp.dropped_index) < MAX_SAMPLES)

	// Closing a set stops intake while the set is evaluated.
	`ORAV_ASSERT_NXT(a_close_busy, req_valid && req_ready && req.last, !req_ready)

endmodule

bind outlier_rejecting_average_top orav_checker #(
	.MAX_SAMPLES(MAX_SAMPLES)
) u_orav_checker (.*);
